// ===== design/pqad_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pqad_pkg
// Shared constants and types for the product-quantization distance engine.
// ----------------------------------------------------------------------------
package pqad_pkg;
  localparam int SUBSPACES_DEF = 8;
  localparam int CENTROIDS_DEF = 256;
  localparam int SUB_DIM_DEF   = 16;
  localparam int ELEM_BITS_DEF = 16;

  localparam int KIND_W   = 2;
  localparam int SUB_W    = 3;
  localparam int CEN_W    = 8;
  localparam int ELEM_W   = 4;
  localparam int VAL_W    = 16;
  localparam int ACC_W    = 37;
  localparam int DIST_W   = 48;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 9;

  typedef enum logic [KIND_W-1:0] {
    KIND_CB_WRITE = 2'd0,
    KIND_QUERY    = 2'd1,
    KIND_ENCODE   = 2'd2,
    KIND_SCORE    = 2'd3
  } kind_t;

  localparam logic [CFG_IDX_W-1:0] REG_CENTROIDS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SUB_DIM   = 1'b1;

  localparam logic RES_CODE = 1'b0;
  localparam logic RES_DIST = 1'b1;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SUB_W-1:0]  subspace;
    logic [CEN_W-1:0]  centroid;
    logic [ELEM_W-1:0] element;
    logic [VAL_W-1:0]  value;
    logic              last;
  } req_t;

  typedef struct packed {
    logic              result_kind;
    logic [SUB_W-1:0]  code_subspace;
    logic [CEN_W-1:0]  code;
    logic [DIST_W-1:0] distance;
  } res_t;
endpackage
`default_nettype wire

// ===== design/pqad_stream_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pqad_stream_if
// Valid/ready channel carrying one packed payload.
// ----------------------------------------------------------------------------
interface pqad_stream_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/pqad_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pqad_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pqad_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== design/pq_encode_and_adc_distance.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pq_encode_and_adc_distance
// Product-quantization encoder and asymmetric distance scorer.
// ----------------------------------------------------------------------------
// Codebook writes are taken in the idle state. A score code is one
// distance-table read added to the running sum; the closing code of a vector
// also passes through the send state to load its result. Query and encode
// elements sweep the centroids in use through a pipeline around the codebook
// read, square and table/accumulator read-modify-write, one centroid per
// cycle. The closing encode element runs a second sweep for the argmin over
// the accumulator memory. One request is worked at a time; a finished result
// waits in the output register while the next request is taken.
// Memories hold no reset value; no clearing pass.
module pq_encode_and_adc_distance
  import pqad_pkg::*;
#(
  parameter int SUBSPACES = SUBSPACES_DEF,
  parameter int CENTROIDS = CENTROIDS_DEF,
  parameter int SUB_DIM   = SUB_DIM_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data,
  pqad_stream_if.sink               req,
  pqad_stream_if.source             res
);
  localparam int SS_W  = (SUBSPACES > 1) ? $clog2(SUBSPACES) : 1;
  localparam int C_W   = $clog2(CENTROIDS);
  localparam int D_W   = (SUB_DIM > 1) ? $clog2(SUB_DIM) : 1;
  localparam int CB_D  = SUBSPACES * CENTROIDS * SUB_DIM;
  localparam int CB_W  = $clog2(CB_D);
  localparam int TB_D  = SUBSPACES * CENTROIDS;
  localparam int TB_W  = (TB_D > 1) ? $clog2(TB_D) : 1;
  localparam int CNT_W = C_W + 1;
  localparam logic [ACC_W-1:0]  MAX_ACC  = {ACC_W{1'b1}};
  localparam logic [DIST_W-1:0] MAX_DIST = {DIST_W{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE, S_SWEEP, S_DRAIN, S_MIN, S_SCORE_RD, S_SCORE_ADD, S_SEND
  } state_t;

  req_t r_in;
  assign r_in = req_t'(req.data);

  state_t              state;
  logic [CNT_W-1:0]    cen_cfg;
  logic [5:0]          dim_cfg;
  logic [CNT_W-1:0]    nc;
  logic [5:0]          nd;
  logic [DIST_W-1:0]   score_sum;
  res_t                out_r;
  logic                out_valid;

  logic                is_query;
  logic                elem_zero;
  logic                do_min;
  logic [SS_W-1:0]     sub;
  logic [D_W-1:0]      elem;
  logic signed [VAL_W-1:0] qval;
  logic                score_last;
  logic                score_hit;
  logic [CNT_W-1:0]    idx;

  // pipeline: p1 codebook data valid, p2 squared, p3 old entry valid
  logic                p1_v, p2_v, p3_v;
  logic [C_W-1:0]      p1_c, p2_c, p3_c;
  logic [ACC_W-1:0]    p3_sq;
  logic [ACC_W-1:0]    p2_sq;
  logic                m_v;
  logic [C_W-1:0]      m_c;
  logic [ACC_W-1:0]    best;
  logic [C_W-1:0]      best_i;
  logic                best_set;

  always_comb begin
    nc = cen_cfg;
    if (cen_cfg == '0) nc = CNT_W'(1);
    if (cen_cfg > CNT_W'(CENTROIDS)) nc = CNT_W'(CENTROIDS);
    nd = dim_cfg;
    if (dim_cfg == '0) nd = 6'd1;
    if (dim_cfg > 6'(SUB_DIM)) nd = 6'(SUB_DIM);
  end

  // codebook
  logic              cb_we;
  logic [CB_W-1:0]   cb_waddr, cb_raddr;
  logic [VAL_W-1:0]  cb_rdata;
  logic              req_ok_sub;
  assign req_ok_sub = 32'(r_in.subspace) < SUBSPACES;
  assign cb_we = req.valid && req.ready && r_in.kind == KIND_CB_WRITE && req_ok_sub &&
                 32'(r_in.centroid) < CENTROIDS && 32'(r_in.element) < SUB_DIM;
  assign cb_waddr = CB_W'((32'(r_in.subspace) * CENTROIDS + 32'(r_in.centroid)) * SUB_DIM
                          + 32'(r_in.element));
  assign cb_raddr = CB_W'((32'(sub) * CENTROIDS + 32'(idx[C_W-1:0])) * SUB_DIM + 32'(elem));

  pqad_ram #(.WIDTH(VAL_W), .DEPTH(CB_D)) u_cb (
    .clk(clk), .we(cb_we), .waddr(cb_waddr), .wdata(r_in.value),
    .raddr(cb_raddr), .rdata(cb_rdata)
  );

  // distance table
  logic              tb_we;
  logic [TB_W-1:0]   tb_waddr, tb_raddr;
  logic [ACC_W-1:0]  tb_wdata, tb_rdata;
  logic [TB_W-1:0]   score_addr;
  // encode accumulators
  logic              ac_we;
  logic [C_W-1:0]    ac_raddr;
  logic [ACC_W-1:0]  ac_wdata, ac_rdata;

  pqad_ram #(.WIDTH(ACC_W), .DEPTH(TB_D)) u_tb (
    .clk(clk), .we(tb_we), .waddr(tb_waddr), .wdata(tb_wdata),
    .raddr(tb_raddr), .rdata(tb_rdata)
  );
  pqad_ram #(.WIDTH(ACC_W), .DEPTH(CENTROIDS)) u_ac (
    .clk(clk), .we(ac_we), .waddr(p3_c), .wdata(ac_wdata),
    .raddr(ac_raddr), .rdata(ac_rdata)
  );

  // read of old entry at p2 stage; each centroid is touched once per sweep
  assign tb_raddr = (state == S_IDLE)
                    ? TB_W'(32'(r_in.subspace) * CENTROIDS + 32'(r_in.centroid))
                    : (state == S_SCORE_RD) ? score_addr
                    : TB_W'(32'(sub) * CENTROIDS + 32'(p2_c));
  assign ac_raddr = (state == S_MIN) ? idx[C_W-1:0] : p2_c;
  assign tb_waddr = TB_W'(32'(sub) * CENTROIDS + 32'(p3_c));

  logic [ACC_W-1:0] old_e;
  logic [ACC_W:0]   sum_e;
  assign old_e = elem_zero ? '0 : (is_query ? tb_rdata : ac_rdata);
  assign sum_e = {1'b0, old_e} + {1'b0, p3_sq};
  assign tb_wdata = sum_e[ACC_W] ? MAX_ACC : sum_e[ACC_W-1:0];
  assign ac_wdata = tb_wdata;
  assign tb_we = p3_v && is_query;
  assign ac_we = p3_v && !is_query;

  // square of difference, saturated to 37 bits
  logic signed [VAL_W:0] diff;
  logic [VAL_W:0]        mag;
  logic [2*VAL_W+1:0]    sq;
  assign diff = {qval[VAL_W-1], qval} - {cb_rdata[VAL_W-1], cb_rdata};
  assign mag  = diff[VAL_W] ? (VAL_W+1)'(0) - diff : diff;
  assign sq   = mag * mag;

  logic [DIST_W:0] ssum;
  assign ssum = {1'b0, score_sum} + {1'b0, (score_hit ? 11'd0 : 11'd0), tb_rdata};

  assign req.ready = (state == S_IDLE);
  assign res.valid = out_valid;
  assign res.data  = out_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cen_cfg   <= CNT_W'(CENTROIDS);
      dim_cfg   <= 6'(SUB_DIM);
      score_sum <= '0;
      out_valid <= 1'b0;
      p1_v <= 1'b0; p2_v <= 1'b0; p3_v <= 1'b0; m_v <= 1'b0;
      idx  <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_CENTROIDS) cen_cfg <= CNT_W'(cfg_data);
        if (cfg_index == REG_SUB_DIM)   dim_cfg <= 6'(cfg_data[4:0]);
      end
      if (out_valid && res.ready && state != S_SEND) out_valid <= 1'b0;
      p1_v <= (state == S_SWEEP);
      p2_v <= p1_v; p2_c <= p1_c;
      p2_sq <= (sq > 34'(MAX_ACC)) ? MAX_ACC : ACC_W'(sq);
      p3_v <= p2_v; p3_c <= p2_c; p3_sq <= p2_sq;
      m_v  <= (state == S_MIN) && (idx != nc);
      unique case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            sub        <= SS_W'(r_in.subspace);
            elem       <= D_W'(r_in.element);
            qval       <= r_in.value;
            is_query   <= r_in.kind == KIND_QUERY;
            elem_zero  <= r_in.element == '0;
            do_min     <= r_in.kind == KIND_ENCODE && 6'(r_in.element) == nd - 6'd1;
            score_last <= r_in.last;
            score_hit  <= req_ok_sub && 32'(r_in.centroid) < CENTROIDS;
            score_addr <= TB_W'(32'(r_in.subspace) * CENTROIDS + 32'(r_in.centroid));
            idx        <= '0;
            if (r_in.kind == KIND_SCORE) begin
              state <= S_SCORE_RD;
            end else if ((r_in.kind == KIND_QUERY || r_in.kind == KIND_ENCODE) &&
                         req_ok_sub && 6'(r_in.element) < nd) begin
              state <= S_SWEEP;
            end
          end
        end
        S_SWEEP: begin
          p1_c <= idx[C_W-1:0];
          idx  <= idx + CNT_W'(1);
          if (idx + CNT_W'(1) == nc) state <= S_DRAIN;
        end
        S_DRAIN: begin
          if (!p1_v && !p2_v && !p3_v) begin
            idx      <= '0;
            best_set <= 1'b0;
            state    <= do_min ? S_MIN : S_IDLE;
          end
        end
        S_MIN: begin
          if (idx != nc) begin
            m_c <= idx[C_W-1:0];
            idx <= idx + CNT_W'(1);
          end
          if (m_v) begin
            if (!best_set || ac_rdata < best) begin
              best   <= ac_rdata;
              best_i <= m_c;
            end
            best_set <= 1'b1;
          end
          if (idx == nc && !m_v && best_set) state <= S_SEND;
        end
        S_SCORE_RD: state <= S_SCORE_ADD;
        S_SCORE_ADD: begin
          if (score_hit) begin
            score_sum <= ssum[DIST_W] ? MAX_DIST : ssum[DIST_W-1:0];
          end
          if (score_last) state <= S_SEND;
          else state <= S_IDLE;
        end
        S_SEND: begin
          if (!out_valid || res.ready) begin
            out_valid <= 1'b1;
            if (do_min) begin
              out_r <= '{RES_CODE, SUB_W'(sub), CEN_W'(best_i), '0};
            end else begin
              out_r <= '{RES_DIST, '0, '0, score_sum};
              score_sum <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== design/pqad_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pqad_checker
// Port-level checks for the product-quantization engine.
// ----------------------------------------------------------------------------
module pqad_checker
  import pqad_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_ready,
  input wire logic res_valid,
  input wire logic res_ready,
  input wire logic [DIST_W+CEN_W+SUB_W:0] res_data
);
  res_t r;
  assign r = res_t'(res_data);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data)) else $error("result dropped");
  a_code_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && r.result_kind == RES_CODE |-> r.distance == '0) else $error("code dist");
  a_dist_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && r.result_kind == RES_DIST |-> r.code == '0 && r.code_subspace == '0)
    else $error("dist code");
  a_reset: assert property (@(posedge clk)
    rst |=> !res_valid) else $error("result after reset");
endmodule

bind pq_encode_and_adc_distance pqad_checker u_pqad_checker (
  .clk(clk), .rst(rst), .req_valid(req.valid), .req_ready(req.ready),
  .res_valid(res.valid), .res_ready(res.ready), .res_data(res.data)
);
`default_nettype wire
